@@ rtl/core/psvs_pkg.sv @@
// Package for the polyphonic sine voice synth: request codes, queue word type,
// note frequency table and helpers. Used by every module under rtl/core but psvs_ram.
package psvs_pkg;

	localparam logic [1:0] REQ_NOTE_ON  = 2'd0;
	localparam logic [1:0] REQ_NOTE_OFF = 2'd1;
	localparam logic [1:0] REQ_TICK     = 2'd2;
	localparam logic [1:0] REQ_UNUSED   = 2'd3;

	localparam logic [1:0] CFG_INC_PER_HZ   = 2'd0;
	localparam logic [1:0] CFG_ATTACK_STEP  = 2'd1;
	localparam logic [1:0] CFG_RELEASE_STEP = 2'd2;

	localparam int CFG_W = 24;
	localparam int SAMPLE_W = 19;

	// Classified request word passed from front to back
	typedef struct packed {
		logic [1:0]  kind;
		logic [6:0]  note;
		logic [15:0] target;
	} cmd_t;

	// Top octave note frequencies, Hz in Q8
	function automatic logic [21:0] top_octave_q8(input logic [3:0] idx);
		logic [21:0] f;
		unique case (idx)
			4'd0: f = 22'd2143237;
			4'd1: f = 22'd2270680;
			4'd2: f = 22'd2405702;
			4'd3: f = 22'd2548752;
			4'd4: f = 22'd2700309;
			4'd5: f = 22'd2860878;
			4'd6: f = 22'd3030994;
			4'd7: f = 22'd3211227;
			4'd8: f = 22'd3402176;
			4'd9: f = 22'd3604480;
			4'd10: f = 22'd3818814;
			4'd11: f = 22'd4045892;
			default: f = 22'd0;
		endcase
		return f;
	endfunction

	// Frequency in Q8 for a MIDI note (octave shift with round half up)
	function automatic logic [21:0] note_freq(input logic [6:0] note);
		logic [12:0] oct_prod;
		logic [3:0]  oct;
		logic [3:0]  semi;
		logic [3:0]  shift;
		logic [21:0] f;
		logic [22:0] sum;
		// Octave as note * 43 / 512, exact for notes 0..127
		oct_prod = 13'(note) * 13'd43;
		oct = oct_prod[12:9];
		semi = 4'(note - 7'(oct) * 7'd12);
		shift = 4'd10 - oct;
		f = top_octave_q8(semi);
		sum = {1'b0, f};
		if (shift != 4'd0) begin
			sum = sum + (23'd1 << (shift - 4'd1));
		end
		return 22'(sum >> shift);
	endfunction

	// Target level from velocity: (vel * 22938 + 63) / 127
	// split as vel * 180 + (vel * 78 + 63) / 127, the remainder part by reciprocal
	function automatic logic [15:0] vel_target(input logic [6:0] vel);
		logic [13:0] rem_num;
		logic [27:0] rem_prod;
		rem_num = 14'(vel) * 14'd78 + 14'd63;
		rem_prod = 28'(rem_num) * 28'd8257;
		return 16'(vel) * 16'd180 + 16'(rem_prod[27:20]);
	endfunction

	// Quarter-wave polynomial sine entry, Q1.15, elaboration-time table build
	function automatic logic signed [15:0] sine_entry(input int i, input int ib);
		longint unsigned quarter;
		longint unsigned quad;
		longint unsigned r;
		longint unsigned num;
		longint unsigned t;
		longint unsigned t2;
		longint unsigned p;
		longint unsigned s;
		longint unsigned v;
		longint unsigned c [6];
		c[0] = 64'd1686629713; c[1] = 64'd693598667; c[2] = 64'd85569306;
		c[3] = 64'd5026994; c[4] = 64'd172273; c[5] = 64'd3864;
		quarter = 64'd1 << (ib - 2);
		quad = (64'(i) >> (ib - 2)) & 64'd3;
		r = 64'(i) & (quarter - 64'd1);
		num = quad[0] ? (quarter - r) : r;
		t = (num << 30) >> (ib - 2);
		t2 = (t * t) >> 30;
		p = c[5];
		for (int k = 4; k >= 0; k--) begin
			p = c[k] - ((p * t2) >> 30);
		end
		s = (p * t) >> 30;
		v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return quad[1] ? -16'(v) : 16'(v);
	endfunction

endpackage

@@ rtl/core/psvs_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module psvs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ rtl/core/psvs_front.sv @@
// Front end: takes request words, drops unused codes, computes note-on target
// and pushes classified words into a two-entry queue. Depends on psvs_pkg.
module psvs_front import psvs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [6:0] note,
	input  logic [6:0] velocity,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  logic       cmd_pop
);
	cmd_t       fifo_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       accept;

	assign in_stall = (count_q == 2'd2);
	assign accept = in_valid && !in_stall;
	assign push = accept && (req_type != REQ_UNUSED);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd = fifo_q[rptr_q];

	// Write classified word
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= '{kind: req_type, note: note, target: vel_target(velocity)};
		end
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (cmd_pop) rptr_q <= !rptr_q;
			count_q <= 2'(count_q + {1'b0, push} - {1'b0, cmd_pop});
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2) else $error("queue overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid) else $error("pop from empty queue");
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2) |-> !push) else $error("push while full");
endmodule

@@ rtl/core/psvs_back.sv @@
// Back end: voice sequencer that walks all slots once per tick word,
// voice state in flip-flops (flags, note, target) and RAM (phase, level).
// Depends on psvs_pkg and psvs_ram.
module psvs_back import psvs_pkg::*; #(
	parameter int VOICES = 20,
	parameter int SINE_INDEX_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  cmd_t                       cmd,
	output logic                       cmd_pop,
	input  logic [23:0]                inc_per_hz,
	input  logic [15:0]                attack_step,
	input  logic [15:0]                release_step,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] sample
);
	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CW = $clog2(VOICES + 1);
	localparam int ROM_SIZE = 1 << SINE_INDEX_BITS;
	localparam int ACC_W = 40;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ON   = 3'd1;
	localparam logic [2:0] ST_OFF  = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_TICK = 3'd4;
	localparam logic [2:0] ST_MAC  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	function automatic logic signed [15:0] rom_arr_dummy(input int i);
		return sine_entry(i, SINE_INDEX_BITS);
	endfunction

	typedef logic signed [15:0] rom_t [ROM_SIZE];
	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i < ROM_SIZE; i++) begin
			r[i] = rom_arr_dummy(i);
		end
		return r;
	endfunction

	localparam logic signed [15:0] SINE_ROM [ROM_SIZE] = build_rom();

	logic [2:0]  state_q;
	cmd_t        cmd_q;
	logic [CW-1:0] idx_q;
	logic [VOICES-1:0] active_q;
	logic [VOICES-1:0] rel_q;
	logic [VOICES-1:0] lv_init_q;
	logic [6:0]  note_q [VOICES];
	logic [15:0] target_q [VOICES];
	logic signed [ACC_W-1:0] acc_q;
	logic        out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	// RAM ports
	logic        ph_we;
	logic [VW-1:0] ph_waddr;
	logic [31:0] ph_wdata;
	logic [31:0] ph_rdata;
	logic        lv_we;
	logic [VW-1:0] lv_waddr;
	logic [15:0] lv_wdata;
	logic [15:0] lv_rdata;
	logic [15:0] lv_rd;
	logic [VW-1:0] vidx;

	// Pipeline registers for the tick mac
	logic signed [15:0] sine_s1;
	logic [15:0] lvl_s1;
	logic        mac_en_s1;
	logic signed [32:0] mac_prod;

	// Slot search for note-on
	logic [CW-1:0] slot;
	logic          slot_found;
	logic [31:0] inc_val;
	logic [45:0] inc_prod;
	logic [16:0] lvl_up;
	logic [15:0] lvl_new;
	logic        free_voice;

	assign vidx = idx_q[VW-1:0];

	psvs_ram #(.WIDTH(32), .DEPTH(VOICES)) u_phase (
		.clk(clk), .we(ph_we), .waddr(ph_waddr), .wdata(ph_wdata),
		.raddr(vidx), .rdata(ph_rdata));
	psvs_ram #(.WIDTH(16), .DEPTH(VOICES)) u_level (
		.clk(clk), .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata),
		.raddr(vidx), .rdata(lv_rdata));

	// Read zero for a level slot not yet written since reset
	assign lv_rd = lv_init_q[vidx] ? lv_rdata : 16'd0;

	// Pick slot: same active note, then free, then releasing
	always_comb begin
		slot = '0;
		slot_found = 1'b0;
		for (int v = VOICES - 1; v >= 0; v--) begin
			if (rel_q[v]) begin
				slot = CW'(v);
				slot_found = 1'b1;
			end
		end
		for (int v = VOICES - 1; v >= 0; v--) begin
			if (!active_q[v]) begin
				slot = CW'(v);
				slot_found = 1'b1;
			end
		end
		for (int v = VOICES - 1; v >= 0; v--) begin
			if (active_q[v] && note_q[v] == cmd_q.note) begin
				slot = CW'(v);
				slot_found = 1'b1;
			end
		end
	end

	// Envelope and phase step of the voice being visited
	assign inc_prod = 46'(note_freq(note_q[vidx])) * 46'(inc_per_hz);
	assign inc_val = inc_prod[39:8];
	assign lvl_up = {1'b0, lv_rd} + {1'b0, attack_step};
	assign free_voice = rel_q[vidx] && (lv_rd <= release_step);
	always_comb begin
		if (rel_q[vidx]) begin
			lvl_new = free_voice ? 16'd0 : 16'(lv_rd - release_step);
		end else begin
			lvl_new = (lvl_up < {1'b0, target_q[vidx]}) ? lvl_up[15:0] : target_q[vidx];
		end
	end

	always_comb begin
		ph_we = 1'b0;
		ph_waddr = vidx;
		ph_wdata = ph_rdata + inc_val;
		lv_we = 1'b0;
		lv_waddr = vidx;
		lv_wdata = lvl_new;
		if (state_q == ST_ON && slot_found) begin
			ph_we = 1'b1;
			ph_waddr = slot[VW-1:0];
			ph_wdata = '0;
		end else if (state_q == ST_TICK && active_q[vidx]) begin
			lv_we = 1'b1;
			ph_we = !free_voice;
		end
	end

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign out_valid = out_valid_q;
	assign sample = sample_q;
	assign mac_prod = sine_s1 * $signed({1'b0, lvl_s1});

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			active_q <= '0;
			rel_q <= '0;
			lv_init_q <= '0;
			out_valid_q <= 1'b0;
			mac_en_s1 <= 1'b0;
		end else begin
			mac_en_s1 <= (state_q == ST_TICK) && active_q[vidx] && !free_voice;
			if (lv_we) lv_init_q[vidx] <= 1'b1;
			if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (cmd_valid) begin
						unique case (cmd.kind)
							REQ_NOTE_ON: state_q <= ST_ON;
							REQ_NOTE_OFF: state_q <= ST_OFF;
							default: state_q <= ST_RD;
						endcase
					end
				end
				ST_ON: begin
					if (slot_found) begin
						active_q[slot[VW-1:0]] <= 1'b1;
						rel_q[slot[VW-1:0]] <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
				ST_OFF: begin
					for (int v = 0; v < VOICES; v++) begin
						if (active_q[v] && note_q[v] == cmd_q.note) rel_q[v] <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_RD: state_q <= ST_TICK;
				ST_TICK: begin
					if (active_q[vidx] && free_voice) begin
						active_q[vidx] <= 1'b0;
						rel_q[vidx] <= 1'b0;
					end
					if (idx_q == CW'(VOICES - 1)) begin
						state_q <= ST_MAC;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_MAC: state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture word, notes and targets; stage the mac operands
	always_ff @(posedge clk) begin
		if (cmd_pop) cmd_q <= cmd;
		if (state_q == ST_ON && slot_found) begin
			note_q[slot[VW-1:0]] <= cmd_q.note;
			target_q[slot[VW-1:0]] <= cmd_q.target;
		end
		sine_s1 <= SINE_ROM[ph_rdata[31 -: SINE_INDEX_BITS]];
		lvl_s1 <= lvl_new;
		if (cmd_pop) begin
			acc_q <= '0;
		end else if (mac_en_s1) begin
			acc_q <= acc_q + ACC_W'(mac_prod);
		end
		if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
			if ((acc_q >>> 16) > ACC_W'(262143)) sample_q <= SAMPLE_W'(262143);
			else if ((acc_q >>> 16) < -ACC_W'(262144)) sample_q <= SAMPLE_W'(-262144);
			else sample_q <= SAMPLE_W'(acc_q >>> 16);
		end
	end

	a_rel_implies_active: assert property (@(posedge clk) disable iff (!arst_n)
		(rel_q & ~active_q) == '0) else $error("releasing voice not active");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> state_q == ST_IDLE) else $error("pop while busy");
	a_out_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT) else $error("stray sample");
endmodule

@@ rtl/core/polyphonic_sine_voice_synth.sv @@
// Top level of the polyphonic sine voice synth: configuration registers,
// front end queue and voice back end. Depends on psvs_pkg, psvs_front, psvs_back.
//
// Note-on and note-off words pass through the ON or OFF state of the back end;
// a tick walks every voice slot through the phase and level RAMs, with a read
// state and an update state per voice, then the MAC and OUT states before its
// sample appears, and it waits in its last step while the previous sample is
// still untaken. A two-word queue lets the input side keep accepting while the
// voice sequencer is busy, and the sample sits in an output register until taken.
module polyphonic_sine_voice_synth import psvs_pkg::*; #(
	parameter int VOICES = 20,
	parameter int SINE_INDEX_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 req_type,
	input  logic [6:0]                 note,
	input  logic [6:0]                 velocity,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] sample
);
	logic [23:0] inc_per_hz_q;
	logic [15:0] attack_step_q;
	logic [15:0] release_step_q;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_per_hz_q <= 24'd89478;
			attack_step_q <= 16'd273;
			release_step_q <= 16'd5;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INC_PER_HZ: inc_per_hz_q <= cfg_data;
				CFG_ATTACK_STEP: attack_step_q <= cfg_data[15:0];
				CFG_RELEASE_STEP: release_step_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	psvs_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .note(note), .velocity(velocity),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop));

	psvs_back #(.VOICES(VOICES), .SINE_INDEX_BITS(SINE_INDEX_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_pop(cmd_pop), .inc_per_hz(inc_per_hz_q), .attack_step(attack_step_q),
		.release_step(release_step_q), .out_valid(out_valid),
		.out_stall(out_stall), .sample(sample));
endmodule

@@ tb/psvs_mix_checker.sv @@
// Checker for the polyphonic sine voice synth: watches the request, config and
// sample ports, keeps its own voice state and compares every mixed sample.
// Depends on psvs_pkg for request and register codes.
module psvs_mix_checker import psvs_pkg::*; #(
	parameter int VOICES = 20,
	parameter int SINE_INDEX_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [1:0]                 req_type,
	input  logic [6:0]                 note,
	input  logic [6:0]                 velocity,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	output int                         fail_count,
	output int                         pending_samples,
	output int                         samples_seen
);
	localparam int ROM_N = 1 << SINE_INDEX_BITS;
	localparam int QTR = ROM_N / 4;

	logic [23:0] inc_per_hz_q;
	logic [15:0] attack_q;
	logic [15:0] release_q;
	bit          v_on [VOICES];
	bit          v_rel [VOICES];
	logic [6:0]  v_note [VOICES];
	logic [31:0] v_phase [VOICES];
	logic [16:0] v_level [VOICES];
	logic [15:0] v_target [VOICES];
	int          sine_tab [ROM_N];
	logic signed [SAMPLE_W-1:0] expected_samples [$];

	// Quarter-wave polynomial, Q30 Horner steps
	function automatic int calc_sine(int i);
		longint unsigned cf [6];
		longint unsigned quad, r, num, t, t2, p, s, v;
		cf[0] = 1686629713; cf[1] = 693598667; cf[2] = 85569306;
		cf[3] = 5026994; cf[4] = 172273; cf[5] = 3864;
		quad = (i / QTR) & 3;
		r = i % QTR;
		num = quad[0] ? (QTR - r) : r;
		t = (num << 30) / QTR;
		t2 = (t * t) >> 30;
		p = cf[5];
		for (int k = 4; k >= 0; k--) p = cf[k] - ((p * t2) >> 30);
		s = (p * t) >> 30;
		v = (s * 32767 + (64'd1 << 29)) >> 30;
		if (v > 32767) v = 32767;
		return quad[1] ? -int'(v) : int'(v);
	endfunction

	function automatic logic [31:0] note_step(logic [6:0] n);
		longint unsigned oct_tab [12];
		longint unsigned f;
		int sh;
		oct_tab = '{2143237, 2270680, 2405702, 2548752, 2700309, 2860878,
			3030994, 3211227, 3402176, 3604480, 3818814, 4045892};
		sh = 10 - n / 12;
		f = oct_tab[n % 12];
		if (sh > 0) f = (f + (64'd1 << (sh - 1))) >> sh;
		return 32'((f * inc_per_hz_q) >> 8);
	endfunction

	task automatic apply_note_on(logic [6:0] n, logic [6:0] vel);
		int slot;
		slot = -1;
		for (int v = 0; v < VOICES && slot < 0; v++) if (v_on[v] && v_note[v] == n) slot = v;
		for (int v = 0; v < VOICES && slot < 0; v++) if (!v_on[v]) slot = v;
		for (int v = 0; v < VOICES && slot < 0; v++) if (v_rel[v]) slot = v;
		if (slot >= 0) begin
			v_note[slot] = n;
			v_phase[slot] = 0;
			v_target[slot] = 16'((int'(vel) * 22938 + 63) / 127);
			v_rel[slot] = 0;
			v_on[slot] = 1;
		end
	endtask

	// Advance every voice one sample and return the saturated mix
	function automatic logic signed [SAMPLE_W-1:0] mix_tick();
		longint acc, q;
		logic [16:0] nl;
		acc = 0;
		for (int v = 0; v < VOICES; v++) begin
			if (!v_on[v]) continue;
			if (v_rel[v]) begin
				if (v_level[v] <= release_q) begin
					v_level[v] = 0; v_on[v] = 0; v_rel[v] = 0;
					continue;
				end
				v_level[v] = v_level[v] - release_q;
			end else begin
				nl = v_level[v] + attack_q;
				v_level[v] = (nl < v_target[v]) ? nl : 17'(v_target[v]);
			end
			acc += longint'(sine_tab[v_phase[v] >> (32 - SINE_INDEX_BITS)])
				* longint'(v_level[v]);
			v_phase[v] = v_phase[v] + note_step(v_note[v]);
		end
		q = (acc >= 0) ? acc / 65536 : -((-acc + 65535) / 65536);
		if (q > 262143) q = 262143;
		if (q < -262144) q = -262144;
		return SAMPLE_W'(q);
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	initial begin
		for (int i = 0; i < ROM_N; i++) sine_tab[i] = calc_sine(i);
	end

	// Track config writes and requests; check each taken sample word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_per_hz_q <= 24'd89478;
			attack_q <= 16'd273;
			release_q <= 16'd5;
			for (int v = 0; v < VOICES; v++) begin
				v_on[v] = 0; v_rel[v] = 0; v_note[v] = 0;
				v_phase[v] = 0; v_level[v] = 0; v_target[v] = 0;
			end
			expected_samples.delete();
			pending_samples = 0;
			fail_count = 0;
			samples_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_INC_PER_HZ:   inc_per_hz_q <= cfg_data;
					CFG_ATTACK_STEP:  attack_q <= cfg_data[15:0];
					CFG_RELEASE_STEP: release_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				samples_seen++;
				if (expected_samples.size() == 0)
					report_mismatch($sformatf("sample %0d with none expected", sample));
				else if (expected_samples[0] !== sample) begin
					report_mismatch($sformatf("sample got %0d exp %0d",
						sample, expected_samples[0]));
					void'(expected_samples.pop_front());
				end else
					void'(expected_samples.pop_front());
			end
			if (in_valid && !in_stall) begin
				case (req_type)
					REQ_NOTE_ON: apply_note_on(note, velocity);
					REQ_NOTE_OFF:
						for (int v = 0; v < VOICES; v++)
							if (v_on[v] && !v_rel[v] && v_note[v] == note) v_rel[v] = 1;
					REQ_TICK: expected_samples.push_back(mix_tick());
					default: ;
				endcase
			end
			pending_samples = expected_samples.size();
		end
	end

	final begin
		if (expected_samples.size() != 0)
			$display("%0d samples never arrived", expected_samples.size());
	end
endmodule

@@ tb/tb_polyphonic_sine_voice_synth.sv @@
// Top of the polyphonic sine voice synth testbench: clock, reset, requests,
// config phases and verdict. Depends on psvs_pkg, the synth and psvs_mix_checker.
module tb_polyphonic_sine_voice_synth;
	import psvs_pkg::*;

	logic                       clk = 0;
	logic                       arst_n = 0;
	logic                       cfg_we = 0;
	logic [1:0]                 cfg_index = '0;
	logic [CFG_W-1:0]           cfg_data = '0;
	logic                       in_valid = 0;
	logic                       in_stall;
	logic [1:0]                 req_type = '0;
	logic [6:0]                 note = '0;
	logic [6:0]                 velocity = '0;
	logic                       out_valid;
	logic                       out_stall = 0;
	logic signed [SAMPLE_W-1:0] sample;
	int                         fail_count, pending_samples, samples_seen;
	int                         words_sent = 0;

	polyphonic_sine_voice_synth dut (.*);
	psvs_mix_checker chk (.*);

	always #4 clk = ~clk;

	function automatic int gap_len();
		return ($urandom_range(9) == 0) ? $urandom_range(60, 10) : $urandom_range(2);
	endfunction

	// Hold the word until taken, then sometimes drop valid for a random gap
	task automatic send_word(logic [1:0] t, logic [6:0] n, logic [6:0] v);
		int g;
		in_valid <= 1; req_type <= t; note <= n; velocity <= v;
		do @(posedge clk); while (in_stall);
		words_sent++;
		@(negedge clk);
		g = gap_len();
		if (g > 0 && $urandom_range(3) != 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		@(negedge clk);
		while (pending_samples != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// Mostly chords that play, tick and release; some stray words
	task automatic random_phase(int count);
		logic [6:0] held [$];
		int k;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(99);
			if (k < 20 && held.size() < 24) begin
				held.push_back(7'($urandom));
				send_word(REQ_NOTE_ON, held[$], 7'($urandom));
			end else if (k < 30 && held.size() > 0) begin
				k = $urandom_range(held.size() - 1);
				send_word(REQ_NOTE_OFF, held[k], 7'($urandom));
				held.delete(k);
			end else if (k < 34)
				send_word(2'($urandom), 7'($urandom), 7'($urandom));
			else
				send_word(REQ_TICK, 7'($urandom), 7'($urandom));
		end
	endtask

	// Receiver stall: short gaps mostly, a few long, some free stretches
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(99) == 0) begin
				out_stall <= 1;
				repeat ($urandom_range(80, 20)) @(negedge clk);
				out_stall <= 0;
				repeat ($urandom_range(200)) @(negedge clk);
			end else begin
				out_stall <= ($urandom_range(3) == 0);
			end
		end
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: extremes of note and velocity, zero velocity, retrigger,
		// note-off, unused type, a burst of note-ons
		send_word(REQ_TICK, 7'd0, 7'd0);
		send_word(REQ_NOTE_ON, 7'd0, 7'd127);
		send_word(REQ_NOTE_ON, 7'd127, 7'd0);
		send_word(REQ_NOTE_ON, 7'd69, 7'd127);
		send_word(REQ_TICK, 7'd0, 7'd0);
		send_word(REQ_NOTE_ON, 7'd69, 7'd64);
		send_word(REQ_TICK, 7'd127, 7'd127);
		send_word(REQ_NOTE_OFF, 7'd69, 7'd0);
		send_word(REQ_UNUSED, 7'd127, 7'd127);
		for (int i = 0; i < 12; i++) send_word(REQ_NOTE_ON, 7'(40 + i * 7), 7'd127);
		send_word(REQ_TICK, 7'd0, 7'd0);
		drain();

		// Config sweeps, extremes included
		write_reg(CFG_INC_PER_HZ, 24'hFFFFFF);
		write_reg(CFG_ATTACK_STEP, 24'hFFFF);
		write_reg(CFG_RELEASE_STEP, 24'hFFFF);
		random_phase(250);
		drain();
		write_reg(CFG_INC_PER_HZ, 24'd1);
		write_reg(CFG_ATTACK_STEP, 24'd1);
		write_reg(CFG_RELEASE_STEP, 24'd1);
		random_phase(200);
		drain();
		write_reg(CFG_INC_PER_HZ, 24'($urandom));
		write_reg(CFG_ATTACK_STEP, 24'($urandom_range(4000, 1)));
		write_reg(CFG_RELEASE_STEP, 24'($urandom_range(9000, 1)));
		random_phase(350);
		drain();
		write_reg(CFG_INC_PER_HZ, 24'd89478);
		write_reg(CFG_ATTACK_STEP, 24'd2000);
		write_reg(CFG_RELEASE_STEP, 24'd3000);
		random_phase(380);
		drain();

		$display("Sent %0d request words over five register settings, %0d samples checked.",
			words_sent, samples_seen);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#20000000;
		$display("Regression FAIL");
		$finish;
	end
endmodule

@@ polyphonic_sine_voice_synth.f @@
rtl/core/psvs_pkg.sv
rtl/core/psvs_ram.sv
rtl/core/psvs_front.sv
rtl/core/psvs_back.sv
rtl/core/polyphonic_sine_voice_synth.sv
tb/psvs_mix_checker.sv
tb/tb_polyphonic_sine_voice_synth.sv
